/* design/assert_macros.svh */
// assertion helpers, clocked on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* design/skn_pkg.sv */
package skn_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 64;
  localparam int RID_W    = 32;
  localparam int POS_W    = 7;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_ROUTE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_MISS = 2'd2,
    STAT_FULL = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_UPDATE = 1'b1
  } state_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [RID_W-1:0] page;
    logic signed [RID_W-1:0] slot;
  } entry_t;

  // compare results a cell keeps for the update cycle
  typedef struct packed {
    logic lt;
    logic le;
    logic eq;
  } flags_t;

  // control broadcast to every cell
  typedef struct packed {
    logic cap;
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

/* design/skn_cell.sv */
module skn_cell (
  input  logic                              clk,
  input  skn_pkg::cell_ctrl_t               ctrl,
  input  logic                              valid,
  input  logic signed [skn_pkg::KEY_W-1:0]  req_key,
  input  skn_pkg::entry_t                   new_entry,
  input  skn_pkg::entry_t                   below_entry,
  input  skn_pkg::entry_t                   above_entry,
  input  logic                              below_lt,
  output skn_pkg::entry_t                   entry,
  output skn_pkg::flags_t                   flags
);

  logic lt;
  logic le;
  logic eq;

  always_comb begin
    lt = valid && ($signed(entry.key) < $signed(req_key));
    le = valid && ($signed(entry.key) <= $signed(req_key));
    eq = valid && (entry.key == req_key);
  end

  always_ff @(posedge clk) begin
    if (ctrl.cap) begin
      flags <= '{lt: lt, le: le, eq: eq};
    end
    // insert: the cell at the lower bound loads, cells above it take the one below
    if (ctrl.ins) begin
      if (!below_lt) begin
        entry <= below_entry;
      end else if (!flags.lt) begin
        entry <= new_entry;
      end
    end
    // remove: cells from the hit upward take the one above
    if (ctrl.rem && !flags.lt) begin
      entry <= above_entry;
    end
  end

endmodule

/* design/skn_bound_enc.sv */
module skn_bound_enc (
  input  logic [skn_pkg::CAPACITY-1:0] therm,
  output logic [skn_pkg::CNT_W-1:0]    bound,
  output logic [skn_pkg::CAPACITY-1:0] last_onehot
);

  logic [skn_pkg::CAPACITY:0] ext;

  always_comb begin
    ext = {1'b0, therm};
    bound = '0;
    // top of the prefix of ones, then its index plus one
    for (int i = 0; i < skn_pkg::CAPACITY; i++) begin
      last_onehot[i] = ext[i] & ~ext[i+1];
      if (last_onehot[i]) begin
        bound = bound | skn_pkg::CNT_W'(i + 1);
      end
    end
  end

endmodule

/* design/sorted_key_node_table_unit.sv */
// Sorted key node table: one index-tree node of up to 64 (key, page, slot) entries kept in
// ascending signed key order in a chain of cells, each cell holding one entry and its own
// comparator. In the accept cycle of a request every cell compares its key with
// the request key; in the next cycle the bounds are encoded from the registered compare flags,
// the result is registered and, for an insert or remove, the cells shift one place toward or
// away from their neighbor. The next request is taken after that, as soon as the result
// register is empty or being drained, so requests never overlap. No clearing pass after reset.
`include "assert_macros.svh"

module sorted_key_node_table_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // key[63:0], new_page[95:64], new_slot[127:96]
  input  logic [1:0]   s_tuser,   // command[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata,   // found_page[31:0], found_slot[63:32], position[70:64],
                                  // entry_count[77:71], zero pad
  output logic [1:0]   m_tuser    // status[1:0]
);

  localparam int CAP = skn_pkg::CAPACITY;

  skn_pkg::state_t                     state;
  skn_pkg::state_t                     state_next;
  logic [skn_pkg::CNT_W-1:0]           count;
  skn_pkg::cmd_t                       req_cmd;
  skn_pkg::entry_t                     req_entry;
  skn_pkg::cell_ctrl_t                 ctrl;

  skn_pkg::entry_t                     entries [CAP];
  skn_pkg::flags_t                     flags   [CAP];
  logic [CAP-1:0]                      valid_vec;
  logic [CAP-1:0]                      lt_vec;
  logic [CAP-1:0]                      le_vec;
  logic [CAP-1:0]                      eq_vec;
  logic [CAP-1:0]                      route_vec;
  logic [CAP-1:0]                      lo_last;
  logic [CAP-1:0]                      route_sel;
  logic [CAP-1:0]                      sel;
  logic [skn_pkg::CNT_W-1:0]           pos_lo;
  logic [skn_pkg::CNT_W-1:0]           pos_up;

  logic                                hit;
  logic                                full;
  logic                                accept;
  logic signed [skn_pkg::RID_W-1:0]    sel_page;
  logic signed [skn_pkg::RID_W-1:0]    sel_slot;

  skn_pkg::status_t                    res_status;
  logic signed [skn_pkg::RID_W-1:0]    res_page;
  logic signed [skn_pkg::RID_W-1:0]    res_slot;
  logic [skn_pkg::CNT_W-1:0]           res_pos;
  logic [skn_pkg::CNT_W-1:0]           count_next;

  skn_pkg::status_t                    out_status;
  logic signed [skn_pkg::RID_W-1:0]    out_page;
  logic signed [skn_pkg::RID_W-1:0]    out_slot;
  logic [skn_pkg::POS_W-1:0]           out_pos;

  assign accept = s_tvalid & s_tready;

  // cell chain
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    skn_pkg::entry_t below_entry;
    skn_pkg::entry_t above_entry;
    logic            below_lt;

    assign valid_vec[i] = (skn_pkg::CNT_W'(i) < count);
    assign lt_vec[i]    = flags[i].lt;
    assign le_vec[i]    = flags[i].le;
    assign eq_vec[i]    = flags[i].eq;

    if (i == 0) begin : g_first
      assign below_entry = entries[i];
      assign below_lt    = 1'b1;
    end else begin : g_mid
      assign below_entry = entries[i-1];
      assign below_lt    = flags[i-1].lt;
    end

    if (i == CAP - 1) begin : g_last
      assign above_entry = entries[i];
    end else begin : g_body
      assign above_entry = entries[i+1];
    end

    skn_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid       (valid_vec[i]),
      .req_key     (s_tdata[63:0]),
      .new_entry   (req_entry),
      .below_entry (below_entry),
      .above_entry (above_entry),
      .below_lt    (below_lt),
      .entry       (entries[i]),
      .flags       (flags[i])
    );
  end

  // upper bound search starts at entry 1, so entry 0 counts as not above the key whenever the node is not empty
  always_comb begin
    route_vec    = le_vec;
    route_vec[0] = le_vec[0] | (count != '0);
  end

  skn_bound_enc u_lower (
    .therm       (lt_vec),
    .bound       (pos_lo),
    .last_onehot (lo_last)
  );

  skn_bound_enc u_upper (
    .therm       (route_vec),
    .bound       (pos_up),
    .last_onehot (route_sel)
  );

  assign hit  = |eq_vec;
  assign full = (count == skn_pkg::CNT_W'(CAP));
  assign sel  = (req_cmd == skn_pkg::CMD_ROUTE) ? route_sel : eq_vec;

  always_comb begin
    sel_page = '0;
    sel_slot = '0;
    for (int i = 0; i < CAP; i++) begin
      if (sel[i]) begin
        sel_page = sel_page | entries[i].page;
        sel_slot = sel_slot | entries[i].slot;
      end
    end
  end

  // result and cell control for the update cycle
  always_comb begin
    res_status = skn_pkg::STAT_MISS;
    res_page   = '1;
    res_slot   = '1;
    res_pos    = pos_lo;
    count_next = count;
    ctrl       = '{cap: accept, ins: 1'b0, rem: 1'b0};
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      skn_pkg::S_IDLE: begin
        s_tready = !rst && (!m_tvalid || m_tready);
        if (accept) begin
          state_next = skn_pkg::S_UPDATE;
        end
      end
      skn_pkg::S_UPDATE: begin
        state_next = skn_pkg::S_IDLE;
        unique case (req_cmd)
          skn_pkg::CMD_LOOKUP: begin
            if (hit) begin
              res_status = skn_pkg::STAT_OK;
              res_page   = sel_page;
              res_slot   = sel_slot;
            end
          end
          skn_pkg::CMD_INSERT: begin
            priority if (hit) begin
              res_status = skn_pkg::STAT_DUP;
              res_page   = sel_page;
              res_slot   = sel_slot;
            end else if (full) begin
              res_status = skn_pkg::STAT_FULL;
            end else begin
              res_status = skn_pkg::STAT_OK;
              ctrl.ins   = 1'b1;
              count_next = count + 1'b1;
            end
          end
          skn_pkg::CMD_REMOVE: begin
            if (hit) begin
              res_status = skn_pkg::STAT_OK;
              res_page   = sel_page;
              res_slot   = sel_slot;
              ctrl.rem   = 1'b1;
              count_next = count - 1'b1;
            end
          end
          skn_pkg::CMD_ROUTE: begin
            res_pos = '0;
            if (count != '0) begin
              res_status = skn_pkg::STAT_OK;
              res_page   = sel_page;
              res_slot   = sel_slot;
              res_pos    = pos_up;
            end
          end
          default: ;
        endcase
      end
      default: state_next = skn_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skn_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (state == skn_pkg::S_UPDATE) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd        <= skn_pkg::cmd_t'(s_tuser);
      req_entry.key  <= s_tdata[63:0];
      req_entry.page <= s_tdata[95:64];
      req_entry.slot <= s_tdata[127:96];
    end
    if (state == skn_pkg::S_UPDATE) begin
      out_status <= res_status;
      out_page   <= res_page;
      out_slot   <= res_slot;
      out_pos    <= skn_pkg::POS_W'(res_pos);
    end
  end

  assign m_tdata = {2'b00, skn_pkg::POS_W'(count), out_pos, out_slot, out_page};
  assign m_tuser = out_status;

  `ASSERT_IMPLIES(a_busy_no_take, state == skn_pkg::S_UPDATE, !s_tready)
  `ASSERT_ALWAYS(a_count_range, count <= skn_pkg::CNT_W'(CAP))
  `ASSERT_IMPLIES(a_unique_hit, state == skn_pkg::S_UPDATE, $onehot0(eq_vec))
  `ASSERT_IMPLIES(a_lower_onehot, state == skn_pkg::S_UPDATE, $onehot0(lo_last))
  `ASSERT_NEXT(a_result_due, state == skn_pkg::S_UPDATE, m_tvalid)
  `ASSERT_NEXT(a_ins_grow, ctrl.ins, count == $past(count) + 1'b1)

endmodule

/* verif/tb_sorted_key_node_table_unit.sv */
module tb_sorted_key_node_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import skn_pkg::*;

  typedef struct {
    status_t    status;
    logic [31:0] page;
    logic [31:0] slot;
    logic [6:0]  pos;
    logic [6:0]  cnt;
  } node_reply_t;

  class node_table_tracker;
    logic signed [63:0] keys [CAPACITY];
    logic [31:0] pages [CAPACITY];
    logic [31:0] slots [CAPACITY];
    int count;
    node_reply_t replies_due [$];
    int errors;

    function int pending();
      return replies_due.size();
    endfunction

    // work out the reply of one request and update the node copy
    function void apply_request(cmd_t cmd, logic signed [63:0] k, logic [31:0] np,
                                logic [31:0] ns);
      node_reply_t r;
      int lb;
      int ub;
      bit hit;
      r.status = STAT_MISS;
      r.page = '1;
      r.slot = '1;
      r.pos = '0;
      if (cmd == CMD_ROUTE) begin
        if (count > 0) begin
          // upper bound searched from entry 1 on
          ub = 1;
          while (ub < count && !(k < keys[ub])) ub++;
          r.status = STAT_OK;
          r.pos = 7'(ub);
          r.page = pages[ub-1];
          r.slot = slots[ub-1];
        end
      end else begin
        lb = 0;
        while (lb < count && keys[lb] < k) lb++;
        hit = (lb < count) && (keys[lb] == k);
        r.pos = 7'(lb);
        case (cmd)
          CMD_LOOKUP: begin
            if (hit) begin
              r.status = STAT_OK;
              r.page = pages[lb];
              r.slot = slots[lb];
            end
          end
          CMD_INSERT: begin
            if (hit) begin
              r.status = STAT_DUP;
              r.page = pages[lb];
              r.slot = slots[lb];
            end else if (count >= CAPACITY) begin
              r.status = STAT_FULL;
            end else begin
              for (int i = count; i > lb; i--) begin
                keys[i] = keys[i-1];
                pages[i] = pages[i-1];
                slots[i] = slots[i-1];
              end
              keys[lb] = k;
              pages[lb] = np;
              slots[lb] = ns;
              count++;
              r.status = STAT_OK;
            end
          end
          default: begin
            if (hit) begin
              r.status = STAT_OK;
              r.page = pages[lb];
              r.slot = slots[lb];
              for (int i = lb; i + 1 < count; i++) begin
                keys[i] = keys[i+1];
                pages[i] = pages[i+1];
                slots[i] = slots[i+1];
              end
              count--;
            end
          end
        endcase
      end
      r.cnt = 7'(count);
      replies_due.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      if (errors < 200)
        $display("mismatch %s: got %0h, want %0h", what, got, want);
      errors++;
    endtask

    task check_reply(status_t st, logic [31:0] pg, logic [31:0] sl, logic [6:0] pos,
                     logic [6:0] cnt);
      node_reply_t r;
      if (replies_due.size() == 0) begin
        report("reply with no request outstanding", 64'(st), '0);
      end else begin
        r = replies_due.pop_front();
        if (st !== r.status) report("status", 64'(st), 64'(r.status));
        if (pg !== r.page) report("found_page", 64'(pg), 64'(r.page));
        if (sl !== r.slot) report("found_slot", 64'(sl), 64'(r.slot));
        if (pos !== r.pos) report("position", 64'(pos), 64'(r.pos));
        if (cnt !== r.cnt) report("entry_count", 64'(cnt), 64'(r.cnt));
      end
    endtask
  endclass

  localparam logic [63:0] KEY_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] KEY_MAX = 64'h7fff_ffff_ffff_ffff;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;   // key[63:0], new_page[95:64], new_slot[127:96]
  logic [1:0]   s_tuser = '0;   // command[1:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [79:0]  m_tdata;        // found_page, found_slot, position, entry_count
  logic [1:0]   m_tuser;        // status[1:0]

  bit idle_en = 1'b1;
  node_table_tracker sb;

  sorted_key_node_table_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= !idle_en || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_reply(status_t'(m_tuser), m_tdata[31:0], m_tdata[63:32], m_tdata[70:64],
                     m_tdata[77:71]);
  end

  task automatic send_request(cmd_t c, logic [63:0] k, logic [31:0] p, logic [31:0] s);
    while (idle_en && $urandom_range(0, 99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {s, p, k};
    s_tuser <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.apply_request(c, k, p, s);
  endtask

  // hold the sender off until every reply is back
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_key(int reuse_pct);
    int r;
    logic [63:0] k;
    r = $urandom_range(0, 99);
    if (r < reuse_pct && sb.count > 0) begin
      k = sb.keys[$urandom_range(0, sb.count - 1)];
      // neighbors of stored keys hit the bound edges
      if ($urandom_range(0, 3) == 0) k = k + 64'($urandom_range(0, 2)) - 64'd1;
    end else if (r < reuse_pct + 20) begin
      k = 64'($urandom_range(0, 40)) - 64'd20;
    end else if (r < reuse_pct + 28) begin
      case ($urandom_range(0, 3))
        0: k = KEY_MIN;
        1: k = KEY_MAX;
        2: k = KEY_MIN + 64'd1;
        default: k = KEY_MAX - 64'd1;
      endcase
    end else begin
      k = {$urandom, $urandom};
    end
    return k;
  endfunction

  function automatic logic [31:0] rand_rid();
    case ($urandom_range(0, 19))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int r;
    int mode;
    cmd_t c;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty node, extremes, duplicates, bounds, route edges
    send_request(CMD_ROUTE, 64'd0, '0, '0);
    send_request(CMD_LOOKUP, KEY_MAX, '0, '0);
    send_request(CMD_REMOVE, KEY_MIN, '0, '0);
    send_request(CMD_INSERT, 64'd0, 32'h7fff_ffff, 32'h8000_0000);
    send_request(CMD_ROUTE, KEY_MIN, '0, '0);
    send_request(CMD_INSERT, KEY_MAX, 32'hffff_ffff, 32'h0000_0000);
    send_request(CMD_INSERT, KEY_MIN, 32'h0000_0000, 32'hffff_ffff);
    send_request(CMD_INSERT, '1, 32'h1234_5678, 32'h9abc_def0);
    send_request(CMD_INSERT, 64'd0, 32'h5555_5555, 32'haaaa_aaaa);
    send_request(CMD_LOOKUP, KEY_MIN, '0, '0);
    send_request(CMD_LOOKUP, KEY_MAX, '0, '0);
    send_request(CMD_LOOKUP, 64'd1, '0, '0);
    send_request(CMD_ROUTE, KEY_MIN, '0, '0);
    send_request(CMD_ROUTE, '1, '0, '0);
    send_request(CMD_ROUTE, KEY_MAX, '0, '0);
    send_request(CMD_ROUTE, 64'd5, '0, '0);
    send_request(CMD_REMOVE, '1, '0, '0);
    send_request(CMD_REMOVE, '1, '0, '0);
    send_request(CMD_REMOVE, KEY_MAX, '0, '0);
    send_request(CMD_REMOVE, KEY_MIN, '0, '0);
    send_request(CMD_LOOKUP, 64'd0, '0, '0);
    send_request(CMD_REMOVE, 64'd0, '0, '0);
    send_request(CMD_ROUTE, KEY_MAX, '0, '0);
    wait_quiet();

    // fill, mixed and drain phases so the node runs full and empty repeatedly
    for (int ph = 0; ph < 12; ph++) begin
      mode = ph % 3;
      idle_en = !(ph == 4 || ph == 5);
      for (int n = 0; n < 150; n++) begin
        r = $urandom_range(0, 99);
        if (mode == 0)
          c = (r < 80) ? CMD_INSERT : (r < 87) ? CMD_LOOKUP : (r < 94) ? CMD_ROUTE : CMD_REMOVE;
        else if (mode == 1)
          c = cmd_t'(r % 4);
        else
          c = (r < 70) ? CMD_REMOVE : (r < 80) ? CMD_INSERT : (r < 90) ? CMD_LOOKUP : CMD_ROUTE;
        send_request(c, rand_key(mode == 0 ? 15 : 65), rand_rid(), rand_rid());
      end
      wait_quiet();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
